// ----- rtl/gdd_pkg.sv -----
// gregorian date difference: shared widths, status codes and calendar tables
// no dependencies
`default_nettype none

package gdd_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_BITS  = 14;
    localparam int STATUS_W   = 2;
    localparam int DIFF_W     = 22;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    // day number of a date below 2^YEAR_BITS stays under 512 * 2^YEAR_BITS
    localparam int NUM_W      = YEAR_BITS + 9;
    localparam int CORR_W     = YEAR_BITS - 2;
    localparam int MOFS_W     = 9;

    // y / 100 as (y * 5243) >> 19, exact for years below 2^15
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_BITS + RECIP_W;
    localparam int Q_W         = YEAR_BITS - 6;
    localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(5243);

    localparam logic [YEAR_BITS-1:0] MIN_YEAR   = YEAR_BITS'(1600);
    localparam logic [8:0]           DAYS_YEAR  = 9'd365;
    localparam logic [6:0]           CENTURY    = 7'd100;
    localparam logic [DIFF_W-1:0]    DIFF_MAX   = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FIRST_BAD   = 2'd1,
        ST_SECOND_BAD  = 2'd2,
        ST_NOT_EARLIER = 2'd3
    } status_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [MOFS_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [MOFS_W-1:0] ofs;
        unique case (m)
            4'd2:    ofs = 9'd31;
            4'd3:    ofs = 9'd59;
            4'd4:    ofs = 9'd90;
            4'd5:    ofs = 9'd120;
            4'd6:    ofs = 9'd151;
            4'd7:    ofs = 9'd181;
            4'd8:    ofs = 9'd212;
            4'd9:    ofs = 9'd243;
            4'd10:   ofs = 9'd273;
            4'd11:   ofs = 9'd304;
            4'd12:   ofs = 9'd334;
            default: ofs = 9'd0;
        endcase
        if (m > 4'd2 && leap) begin
            ofs = ofs + 9'd1;
        end
        return ofs;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gregorian_date_difference_top.sv -----
// gregorian date difference: four-stage pipeline from two dates to a day count
// depends on gdd_pkg
//
// usage: one transaction on the s_ channel carries two dates, the later
// (first) and the earlier (second); one transaction on the m_ channel
// returns a status code in m_tuser and the day count in m_tdata.
// status: ok, first date invalid, second date invalid, second not earlier;
// the day count is zero unless status is ok.
// an accepted pair moves through stages one to four in order to m_tvalid.
// throughput: one pair per cycle unless the receiver stalls; each of the
// four stages holds one pair; the year/100 reciprocal multipliers are in
// stage one and the day-number adders in stage three.
// each stage has its own valid bit and moves when the next stage is free,
// so bubbles collapse and a stalled receiver backs the pipeline up stage
// by stage before s_tready drops; nothing is lost or repeated.
// reset: aresetn low clears all valid bits; s_tready is high the cycle after.
`default_nettype none

module gregorian_date_difference_top
    import gdd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // day_difference
    output logic [M_TDATA_W-1:0]       m_tdata,
    // status
    output logic [STATUS_W-1:0]        m_tuser
);

    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: fields and reciprocal products
    logic                  v1_reg;
    logic [DAY_W-1:0]      d1_reg [2];
    logic [MONTH_W-1:0]    m1_reg [2];
    logic [YEAR_BITS-1:0]  y1_reg [2];
    logic [PROD_W-1:0]     pp1_reg [2];
    logic [PROD_W-1:0]     py1_reg [2];

    logic [DAY_W-1:0]      in_d [2];
    logic [MONTH_W-1:0]    in_m [2];
    logic [YEAR_BITS-1:0]  in_y [2];
    logic [YEAR_BITS-1:0]  in_p [2];

    // stage 2: validity and day-number parts
    logic                  v2_reg;
    logic                  ok2_reg [2];
    logic [NUM_W-1:0]      yb2_reg [2];
    logic [CORR_W-1:0]     corr2_reg [2];
    logic [MOFS_W-1:0]     mofs2_reg [2];
    logic [DAY_W-1:0]      d2_reg [2];

    logic                  ok2_next [2];
    logic [CORR_W-1:0]     corr2_next [2];
    logic [MOFS_W-1:0]     mofs2_next [2];
    logic [YEAR_BITS-1:0]  p1 [2];
    logic [Q_W-1:0]        qp [2];
    logic [Q_W-1:0]        qy [2];
    logic                  leap [2];

    // stage 3: day numbers
    logic                  v3_reg;
    logic                  ok3_reg [2];
    logic [NUM_W-1:0]      n3_reg [2];

    // stage 4: result register
    logic                  v4_reg;
    status_t               st4_reg;
    logic [DIFF_W-1:0]     diff4_reg;
    status_t               st4_next;
    logic [DIFF_W-1:0]     diff4_next;
    logic [NUM_W-1:0]      raw_diff;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign in_d[0] = s_tdata[4:0];
    assign in_m[0] = s_tdata[8:5];
    assign in_y[0] = s_tdata[22:9];
    assign in_d[1] = s_tdata[27:23];
    assign in_m[1] = s_tdata[31:28];
    assign in_y[1] = s_tdata[45:32];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            in_p[i] = YEAR_BITS'(in_y[i] - YEAR_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            for (int i = 0; i < 2; i++) begin
                d1_reg[i]  <= in_d[i];
                m1_reg[i]  <= in_m[i];
                y1_reg[i]  <= in_y[i];
                pp1_reg[i] <= PROD_W'(in_p[i]) * PROD_W'(RECIP100);
                py1_reg[i] <= PROD_W'(in_y[i]) * PROD_W'(RECIP100);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            p1[i]   = YEAR_BITS'(y1_reg[i] - YEAR_BITS'(1));
            qp[i]   = pp1_reg[i][RECIP_SHIFT +: Q_W];
            qy[i]   = py1_reg[i][RECIP_SHIFT +: Q_W];
            leap[i] = (y1_reg[i][1:0] == 2'b00)
                      && ((y1_reg[i] != YEAR_BITS'(qy[i]) * YEAR_BITS'(CENTURY))
                          || (qy[i][1:0] == 2'b00));
            ok2_next[i] = (y1_reg[i] > MIN_YEAR) && (d1_reg[i] != '0)
                          && (d1_reg[i] <= month_days(m1_reg[i], leap[i]));
            corr2_next[i] = CORR_W'(p1[i] >> 2) - CORR_W'(qp[i]) + CORR_W'(qp[i] >> 2);
            mofs2_next[i] = month_start(m1_reg[i], leap[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            for (int i = 0; i < 2; i++) begin
                ok2_reg[i]   <= ok2_next[i];
                yb2_reg[i]   <= NUM_W'(p1[i]) * NUM_W'(DAYS_YEAR);
                corr2_reg[i] <= corr2_next[i];
                mofs2_reg[i] <= mofs2_next[i];
                d2_reg[i]    <= d1_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            for (int i = 0; i < 2; i++) begin
                ok3_reg[i] <= ok2_reg[i];
                n3_reg[i]  <= yb2_reg[i] + NUM_W'(corr2_reg[i])
                              + NUM_W'(mofs2_reg[i]) + NUM_W'(d2_reg[i]);
            end
        end
    end

    always_comb begin
        raw_diff   = NUM_W'(n3_reg[0] - n3_reg[1]);
        diff4_next = '0;
        if (!ok3_reg[0]) begin
            st4_next = ST_FIRST_BAD;
        end else if (!ok3_reg[1]) begin
            st4_next = ST_SECOND_BAD;
        end else if (n3_reg[1] >= n3_reg[0]) begin
            st4_next = ST_NOT_EARLIER;
        end else begin
            st4_next = ST_OK;
            if (raw_diff > NUM_W'(DIFF_MAX)) begin
                diff4_next = DIFF_MAX;
            end else begin
                diff4_next = DIFF_W'(raw_diff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            st4_reg   <= st4_next;
            diff4_reg <= diff4_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = st4_reg;
    assign m_tdata  = M_TDATA_W'(diff4_reg);

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && (st4_reg != ST_OK) |-> diff4_reg == '0)
        else $error("non-ok status with nonzero day count");

    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && (st4_reg == ST_OK) |-> diff4_reg != '0)
        else $error("ok status with zero day count");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !v1_reg && !v2_reg && !v3_reg && !v4_reg)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !rdy3 |=> v2_reg && $stable(n3_reg[0]) && $stable(ok2_reg[0]))
        else $error("stage two lost an item under stall");

endmodule

`default_nettype wire

// ----- tb/date_difference_checker.sv -----
`timescale 1ns / 100ps
// date difference checker: watches both stream channels of the date difference block,
// predicts status and day count for each accepted date pair and compares in order
// depends on gdd_pkg

module date_difference_checker
    import gdd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    output int unsigned          fail_count,
    output int unsigned          pending_count
);

    localparam int MONTH_OFS  = DAY_W;
    localparam int YEAR_OFS   = DAY_W + MONTH_W;
    localparam int SECOND_OFS = DAY_W + MONTH_W + YEAR_BITS;

    typedef struct {
        status_t           status;
        logic [DIFF_W-1:0] days;
    } day_count_t;

    day_count_t expected_counts[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                      input int unsigned y);
        return (y > 1600) && (m >= 1) && (m <= 12) && (d >= 1)
               && (d <= days_in_month(m, y));
    endfunction

    // days since a fixed epoch, month lengths summed one by one
    function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
                                              input int unsigned y);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++) begin
            n += days_in_month(k, y);
        end
        return n + d;
    endfunction

    function automatic day_count_t predict_difference(input logic [S_TDATA_W-1:0] pair);
        int unsigned fd, fm, fy, sd, sm, sy;
        int unsigned later, earlier;
        day_count_t  r;
        fd = 32'(pair[0 +: DAY_W]);
        fm = 32'(pair[MONTH_OFS +: MONTH_W]);
        fy = 32'(pair[YEAR_OFS +: YEAR_BITS]);
        sd = 32'(pair[SECOND_OFS +: DAY_W]);
        sm = 32'(pair[SECOND_OFS + MONTH_OFS +: MONTH_W]);
        sy = 32'(pair[SECOND_OFS + YEAR_OFS +: YEAR_BITS]);
        r.status = ST_OK;
        r.days   = '0;
        if (!date_valid(fd, fm, fy)) begin
            r.status = ST_FIRST_BAD;
        end else if (!date_valid(sd, sm, sy)) begin
            r.status = ST_SECOND_BAD;
        end else begin
            later   = day_index(fd, fm, fy);
            earlier = day_index(sd, sm, sy);
            if (earlier >= later) begin
                r.status = ST_NOT_EARLIER;
            end else if (later - earlier > 32'(DIFF_MAX)) begin
                r.days = DIFF_MAX;
            end else begin
                r.days = DIFF_W'(later - earlier);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : monitor
        day_count_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: status %0d days %0d",
                                              m_tuser, m_tdata[DIFF_W-1:0]));
                end else begin
                    want = expected_counts.pop_front();
                    if (m_tuser != want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                    end
                    if (m_tdata[DIFF_W-1:0] != want.days) begin
                        report_mismatch($sformatf("day count %0d, expected %0d",
                                                  m_tdata[DIFF_W-1:0], want.days));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_counts.push_back(predict_difference(s_tdata));
            end
            pending_count = expected_counts.size();
        end
    end

endmodule

// ----- tb/tb_gregorian_date_difference_top.sv -----
`timescale 1ns / 100ps
// testbench top for the gregorian date difference block: clock, reset, date pair
// stimulus with idle and stall phases, watchdog and final verdict
// depends on gdd_pkg, gregorian_date_difference_top and date_difference_checker

module tb_gregorian_date_difference_top;
    import gdd_pkg::*;

    localparam int HOLD_CYCLES    = 64;
    localparam int QUIET_LIMIT    = 1000;
    localparam int PHASE_ITEMS    = 232;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PAIR_W         = 2 * (DAY_W + MONTH_W + YEAR_BITS);

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int unsigned quiet_cycles   = 0;

    always #10 aclk = ~aclk;

    gregorian_date_difference_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    date_difference_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // one date pair per call; returns at the falling edge after acceptance
    task automatic offer_pair(input logic [DAY_W-1:0] fd, input logic [MONTH_W-1:0] fm,
                              input logic [YEAR_BITS-1:0] fy, input logic [DAY_W-1:0] sd,
                              input logic [MONTH_W-1:0] sm, input logic [YEAR_BITS-1:0] sy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = S_TDATA_W'({sy, sm, sd, fy, fm, fd});
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                             output logic [YEAR_BITS-1:0] y);
        if ($urandom_range(9) != 0) begin
            y = YEAR_BITS'($urandom_range(2600, 1601));
        end else begin
            y = YEAR_BITS'($urandom_range(16383, 1601));
        end
        m = MONTH_W'($urandom_range(12, 1));
        if ($urandom_range(3) != 0) begin
            d = DAY_W'($urandom_range(28, 1));
        end else begin
            d = DAY_W'($urandom_range(31, 1));
        end
    endtask

    // mostly well-formed pairs with the later date first, the rest reversed,
    // equal, one field broken or pure noise
    task automatic random_pair();
        logic [DAY_W-1:0]     ad, bd;
        logic [MONTH_W-1:0]   am, bm;
        logic [YEAR_BITS-1:0] ay, by;
        int unsigned          kind;
        kind = $urandom_range(99);
        pick_date(ad, am, ay);
        pick_date(bd, bm, by);
        if (kind < 4) begin
            {bd, bm, by} = {ad, am, ay};
        end else if (kind < 8) begin
            by = ay;
        end
        if (kind >= 12 && {ay, am, ad} < {by, bm, bd}) begin
            {ad, am, ay, bd, bm, by} = {bd, bm, by, ad, am, ay};
        end
        if (kind >= 95) begin
            {ad, am, ay, bd, bm, by} = PAIR_W'({$urandom, $urandom});
        end else if (kind >= 88) begin
            case ($urandom_range(5))
                0:       ad = DAY_W'($urandom);
                1:       am = MONTH_W'($urandom);
                2:       ay = YEAR_BITS'($urandom);
                3:       bd = DAY_W'($urandom);
                4:       bm = MONTH_W'($urandom);
                default: by = YEAR_BITS'($urandom);
            endcase
        end
        offer_pair(ad, am, ay, bd, bm, by);
    endtask

    // receiver side: random stalls, or one long hold-off on request
    initial begin : receiver
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("gregorian_date_difference_top: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        offer_pair(15, 6, 2024, 1, 1, 2000);
        offer_pair(31, 12, 16383, 1, 1, 1601);
        offer_pair(1, 1, 1602, 31, 12, 1601);
        offer_pair(1, 3, 2000, 28, 2, 2000);
        offer_pair(29, 2, 2024, 28, 2, 2023);
        offer_pair(29, 2, 1900, 1, 1, 1700);
        offer_pair(31, 12, 2400, 29, 2, 2000);
        offer_pair(29, 2, 2100, 1, 1, 1601);
        offer_pair(4, 7, 1776, 4, 7, 1776);
        offer_pair(1, 1, 1700, 2, 1, 1700);
        offer_pair(0, 0, 0, 0, 0, 0);
        offer_pair(31, 15, 16383, 31, 15, 16383);
        offer_pair(1, 0, 2000, 1, 1, 1601);
        offer_pair(10, 5, 2000, 1, 13, 1999);
        offer_pair(10, 5, 2000, 1, 15, 1999);
        offer_pair(1, 1, 1600, 1, 1, 1500);
        offer_pair(1, 1, 1601, 31, 12, 1600);
        offer_pair(10, 5, 2000, 0, 5, 1999);
        offer_pair(31, 4, 2001, 1, 1, 1999);
        offer_pair(30, 2, 2000, 1, 1, 1999);
        offer_pair(31, 1, 9999, 30, 11, 8192);
        offer_pair(1, 1, 16383, 31, 12, 16382);
        offer_pair(30, 9, 3000, 31, 10, 1601);
        offer_pair(31, 12, 9999, 1, 1, 1601);
        offer_pair(15, 8, 1947, 15, 8, 1948);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 40) begin
                    hold_req = 1'b1;
                end
                if (ph == 3 && k == PHASE_ITEMS / 2) begin
                    s_tvalid = 1'b0;
                    while (pending_count != 0) @(negedge aclk);
                end
                random_pair();
            end
        end

        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("gregorian_date_difference_top: match");
        end else begin
            $display("gregorian_date_difference_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/gdd_pkg.sv
rtl/gregorian_date_difference_top.sv
tb/date_difference_checker.sv
tb/tb_gregorian_date_difference_top.sv
